// ===== hw/rtl/gdo_pkg.sv =====
// Shared types, constants and calendar functions for the Gregorian date offset core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gdo_pkg;

	// Width of the signed day offset and of the internal day accumulator
	localparam int OFFSET_WIDTH = 16;
	localparam int ACC_WIDTH    = (OFFSET_WIDTH + 1 > 10) ? OFFSET_WIDTH + 1 : 10;

	// Calendar constants
	localparam logic [13:0] YEAR_MIN   = 14'd1;
	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	localparam int          LEAP_CYCLE = 400;
	localparam int          CENTURY    = 100;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [4:0] LEN_LONG  = 5'd31;
	localparam logic [4:0] LEN_SHORT = 5'd30;
	localparam logic [4:0] LEN_FEB   = 5'd28;
	localparam logic [4:0] LEN_LEAP  = 5'd29;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_DATE = 2'd1,
		ST_RANGE    = 2'd2
	} gdo_status_t;

	// Request and response payloads
	typedef struct packed {
		logic [4:0]                     in_day;
		logic [3:0]                     in_month;
		logic [13:0]                    in_year;
		logic signed [OFFSET_WIDTH-1:0] offset;
	} gdo_req_t;

	typedef struct packed {
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
		logic [8:0]  day_of_year;
		gdo_status_t status;
	} gdo_rsp_t;

	// Sequencer commands to the datapath
	typedef struct packed {
		logic        load;
		logic        mod_step;
		logic        walk_start;
		logic        fwd_step;
		logic        back_step;
		logic        doy_init;
		logic        doy_step;
		logic        done;
		gdo_status_t status;
	} gdo_ctrl_t;

	// Datapath conditions seen by the sequencer
	typedef struct packed {
		logic rem_ge;
		logic date_ok;
		logic carry;
		logic borrow;
		logic year_hi;
		logic year_lo;
		logic mon_hi;
		logic mon_lo;
		logic doy_more;
	} gdo_flags_t;

	// Leap test from the year reduced modulo 400
	function automatic logic leap_of(input logic [8:0] rem);
		return (rem[1:0] == 2'b00) && (rem != 9'(CENTURY)) &&
			(rem != 9'(2 * CENTURY)) && (rem != 9'(3 * CENTURY));
	endfunction

	// Days in a month; codes outside 1..12 fall to the long month
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
			MONTH_FEB: len = leap ? LEN_LEAP : LEN_FEB;
			default: len = LEN_LONG;
		endcase
		return len;
	endfunction

endpackage

// ===== hw/rtl/gdo_dpath.sv =====
// Datapath of the date offset core: date registers and the one shared adder/compare unit.
// Depends on gdo_pkg; driven by gdo_fsm commands.
`timescale 1ns / 1ps

module gdo_dpath import gdo_pkg::*; (
	input  logic        clk,
	input  gdo_req_t    req,
	input  gdo_ctrl_t   ctrl,
	output gdo_flags_t  flags,
	output logic [4:0]  res_day,
	output logic [3:0]  res_month,
	output logic [13:0] res_year,
	output logic [8:0]  res_doy
);

	logic [13:0]                    year_q;
	logic [3:0]                     mon_q;
	logic [13:0]                    rem_q;
	logic [ACC_WIDTH-1:0]           acc_q;
	logic [3:0]                     m_q;
	logic [4:0]                     fday_q;
	logic [OFFSET_WIDTH-1:0]        off_q;

	logic                 leap_now;
	logic                 leap_prev;
	logic [3:0]           mon_prev;
	logic [13:0]          rem_inc;
	logic [13:0]          rem_prev;
	logic [4:0]           len_cur;
	logic [4:0]           len_prev;
	logic [4:0]           len_doy;
	logic [ACC_WIDTH-1:0] len_ext;
	logic [ACC_WIDTH-1:0] addend;
	logic [ACC_WIDTH-1:0] sum;
	logic                 acc_neg;
	logic                 acc_zero;

	// Year residue steps with wrap inside the 400-year cycle
	assign rem_inc  = (rem_q[8:0] == 9'(LEAP_CYCLE - 1)) ? 14'd0 : rem_q + 14'd1;
	assign mon_prev = (mon_q == MONTH_JAN) ? MONTH_DEC : mon_q - 4'd1;
	assign rem_prev = (mon_q != MONTH_JAN) ? rem_q :
		((rem_q[8:0] == 9'd0) ? 14'(LEAP_CYCLE - 1) : rem_q - 14'd1);

	// Month lengths for the current, previous and tallied month
	assign leap_now  = leap_of(rem_q[8:0]);
	assign leap_prev = leap_of(rem_prev[8:0]);
	assign len_cur   = month_len(mon_q, leap_now);
	assign len_prev  = month_len(mon_prev, leap_prev);
	assign len_doy   = month_len(m_q, leap_now);

	// Shared adder: offset on start, minus length on carry, plus length otherwise
	always_comb begin
		if (ctrl.back_step) begin
			len_ext = {{(ACC_WIDTH-5){1'b0}}, len_prev};
		end else if (ctrl.doy_step) begin
			len_ext = {{(ACC_WIDTH-5){1'b0}}, len_doy};
		end else begin
			len_ext = {{(ACC_WIDTH-5){1'b0}}, len_cur};
		end
		if (ctrl.walk_start) begin
			addend = {{(ACC_WIDTH-OFFSET_WIDTH){off_q[OFFSET_WIDTH-1]}}, off_q};
		end else if (ctrl.fwd_step) begin
			addend = ~len_ext + ACC_WIDTH'(1);
		end else begin
			addend = len_ext;
		end
	end
	assign sum = acc_q + addend;

	// Compare unit on the accumulator
	assign acc_neg  = acc_q[ACC_WIDTH-1];
	assign acc_zero = (acc_q == '0);
	assign flags.carry    = !acc_neg && (acc_q > {{(ACC_WIDTH-5){1'b0}}, len_cur});
	assign flags.borrow   = acc_neg || acc_zero;
	assign flags.rem_ge   = (rem_q >= 14'(LEAP_CYCLE));
	assign flags.date_ok  = (year_q >= YEAR_MIN) && (year_q <= YEAR_MAX) &&
		(mon_q >= MONTH_JAN) && (mon_q <= MONTH_DEC) &&
		!acc_neg && !acc_zero && !flags.carry;
	assign flags.year_hi  = (year_q == YEAR_MAX);
	assign flags.year_lo  = (year_q == YEAR_MIN);
	assign flags.mon_hi   = (mon_q == MONTH_DEC);
	assign flags.mon_lo   = (mon_q == MONTH_JAN);
	assign flags.doy_more = (m_q < mon_q);

	// Date registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			year_q <= req.in_year;
			mon_q  <= req.in_month;
			rem_q  <= req.in_year;
			acc_q  <= {{(ACC_WIDTH-5){1'b0}}, req.in_day};
			off_q  <= req.offset;
		end
		if (ctrl.mod_step) begin
			rem_q <= rem_q - 14'(LEAP_CYCLE);
		end
		if (ctrl.walk_start || ctrl.doy_step) begin
			acc_q <= sum;
		end
		if (ctrl.fwd_step) begin
			acc_q <= sum;
			if (mon_q == MONTH_DEC) begin
				mon_q  <= MONTH_JAN;
				year_q <= year_q + 14'd1;
				rem_q  <= rem_inc;
			end else begin
				mon_q <= mon_q + 4'd1;
			end
		end
		if (ctrl.back_step) begin
			acc_q <= sum;
			mon_q <= mon_prev;
			rem_q <= rem_prev;
			if (mon_q == MONTH_JAN) begin
				year_q <= year_q - 14'd1;
			end
		end
		if (ctrl.doy_init) begin
			fday_q <= acc_q[4:0];
			m_q    <= MONTH_JAN;
		end
		if (ctrl.doy_step) begin
			m_q <= m_q + 4'd1;
		end
	end

	assign res_day   = fday_q;
	assign res_month = mon_q;
	assign res_year  = year_q;
	assign res_doy   = acc_q[8:0];

endmodule

// ===== hw/rtl/gdo_fsm.sv =====
// Sequencer of the date offset core: reduce year, check, carry, borrow, tally day of year.
// Depends on gdo_pkg; commands gdo_dpath.
`timescale 1ns / 1ps

module gdo_fsm import gdo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       out_free,
	input  gdo_flags_t flags,
	output logic       idle,
	output gdo_ctrl_t  ctrl
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MOD   = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_FWD   = 7'b0001000,
		S_BACK  = 7'b0010000,
		S_DOY   = 7'b0100000,
		S_DONE  = 7'b1000000
	} gdo_state_t;

	gdo_state_t  state_q, state_d;
	gdo_status_t st_q, st_d;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		ctrl    = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = S_MOD;
				end
			end
			S_MOD: begin
				if (flags.rem_ge) begin
					ctrl.mod_step = 1'b1;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (flags.date_ok) begin
					ctrl.walk_start = 1'b1;
					state_d         = S_FWD;
				end else begin
					st_d    = ST_BAD_DATE;
					state_d = S_DONE;
				end
			end
			S_FWD: begin
				if (!flags.carry) begin
					state_d = S_BACK;
				end else if (flags.mon_hi && flags.year_hi) begin
					st_d    = ST_RANGE;
					state_d = S_DONE;
				end else begin
					ctrl.fwd_step = 1'b1;
				end
			end
			S_BACK: begin
				if (!flags.borrow) begin
					ctrl.doy_init = 1'b1;
					state_d       = S_DOY;
				end else if (flags.mon_lo && flags.year_lo) begin
					st_d    = ST_RANGE;
					state_d = S_DONE;
				end else begin
					ctrl.back_step = 1'b1;
				end
			end
			S_DOY: begin
				if (flags.doy_more) begin
					ctrl.doy_step = 1'b1;
				end else begin
					st_d    = ST_OK;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					ctrl.done = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		ctrl.status = st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result status; meaningful only once the sequencer reaches done
	always_ff @(posedge clk) begin
		st_q <= st_d;
	end

	assign idle = (state_q == S_IDLE);

endmodule

// ===== hw/rtl/gregorian_date_offset_core.sv =====
// Top level of the Gregorian date offset core: handshake, response register, sequencer
// and datapath. Depends on gdo_pkg, gdo_fsm and gdo_dpath.
`timescale 1ns / 1ps

// Adds a signed day offset to a Gregorian date and returns the new date, its day of year
// and a status (ok, invalid start date, result year outside 1..9999). One request is
// worked at a time; req_ready is high only while the sequencer is idle. A valid request
// passes the reduce loop, the date check, the carry and borrow walk and the day of year
// tally, and its response is loaded once the output register is free. The reduce loop
// takes the year modulo 400 in at most 24 steps for a valid year, 40 for the largest
// field value. The carry/borrow walk crosses month boundaries one per cycle, about 1100
// for the largest offset. The day of year tally adds at most 11 months. An invalid start
// date is answered after the reduce loop and the date check. The sequencer is idle again
// when the response appears, so the next request can be accepted as soon as it does.
// All walk and tally steps share one adder/compare unit on the day accumulator.
// The response sits in an output register, so a new request is taken while it waits.
module gregorian_date_offset_core import gdo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  gdo_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output gdo_rsp_t rsp
);

	gdo_ctrl_t   ctrl;
	gdo_flags_t  flags;
	logic        idle;
	logic        out_free;
	logic [4:0]  res_day;
	logic [3:0]  res_month;
	logic [13:0] res_year;
	logic [8:0]  res_doy;
	logic        rsp_valid_q;
	gdo_rsp_t    rsp_q;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = idle;

	gdo_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid),
		.out_free (out_free),
		.flags    (flags),
		.idle     (idle),
		.ctrl     (ctrl)
	);

	gdo_dpath u_dpath (
		.clk       (clk),
		.req       (req),
		.ctrl      (ctrl),
		.flags     (flags),
		.res_day   (res_day),
		.res_month (res_month),
		.res_year  (res_year),
		.res_doy   (res_doy)
	);

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload; fields are zero unless the status is ok
	always_ff @(posedge clk) begin
		if (ctrl.done) begin
			rsp_q.status <= ctrl.status;
			if (ctrl.status == ST_OK) begin
				rsp_q.out_day     <= res_day;
				rsp_q.out_month   <= res_month;
				rsp_q.out_year    <= res_year;
				rsp_q.day_of_year <= res_doy;
			end else begin
				rsp_q.out_day     <= '0;
				rsp_q.out_month   <= '0;
				rsp_q.out_year    <= '0;
				rsp_q.day_of_year <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A request in flight blocks the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while a request is in flight");

	// Error responses carry zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |->
		(rsp.out_day == 5'd0 && rsp.out_month == 4'd0 && rsp.out_year == 14'd0 &&
		rsp.day_of_year == 9'd0))
		else $error("error response with nonzero date fields");

	// Good responses hold a date in range
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_OK) |->
		(rsp.out_month >= MONTH_JAN && rsp.out_month <= MONTH_DEC &&
		rsp.out_day != 5'd0 && rsp.out_year >= YEAR_MIN && rsp.out_year <= YEAR_MAX &&
		rsp.day_of_year >= 9'(rsp.out_day)))
		else $error("ok response with a date out of range");

	// A response is only loaded when the register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.done |-> out_free)
		else $error("response overwritten before it was taken");

	// Status code three never leaves the block
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_BAD_DATE ||
		rsp.status == ST_RANGE))
		else $error("undefined status code on response");

endmodule

// ===== verif/tb_gregorian_date_offset_core.sv =====
// Self-checking testbench for gregorian_date_offset_core: directed date table, then random requests.
// Depends on gdo_pkg and the core RTL; every response is checked against a typed expectation or a calendar predictor.
`timescale 1ns / 1ps

module tb_gregorian_date_offset_core;
	import gdo_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 50;
	localparam int MAX_PRINT    = 200;
	// Worst case is the longest walk per request plus the longest gaps on both sides,
	// for ~525 requests; the limit is several times that.
	localparam int CYCLE_LIMIT  = 3_000_000;

	// Directed case: start date, offset, and a typed response where it is obvious
	typedef struct packed {
		int          d;
		int          m;
		int          y;
		int          off;
		bit          typed;
		int          ed;
		int          em;
		int          ey;
		int          edoy;
		gdo_status_t est;
	} date_case_t;

	localparam int NUM_CASES = 25;

	date_case_t date_table [NUM_CASES] = '{
		// zero offset on valid dates returns the date with its ordinal
		'{1, 1, 1, 0, 1'b1, 1, 1, 1, 1, ST_OK},
		'{31, 12, 9999, 0, 1'b1, 31, 12, 9999, 365, ST_OK},
		'{29, 2, 2000, 0, 1'b1, 29, 2, 2000, 60, ST_OK},
		// walk leaves the year range
		'{31, 12, 9999, 1, 1'b1, 0, 0, 0, 0, ST_RANGE},
		'{1, 1, 1, -1, 1'b1, 0, 0, 0, 0, ST_RANGE},
		'{1, 1, 9999, 32767, 1'b1, 0, 0, 0, 0, ST_RANGE},
		'{31, 12, 1, -32768, 1'b1, 0, 0, 0, 0, ST_RANGE},
		// invalid start dates
		'{0, 1, 2000, 5, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		'{1, 0, 2000, 5, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		'{1, 13, 2000, 5, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		'{31, 15, 16383, -1, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		'{1, 1, 0, 0, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		'{1, 1, 10000, 0, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		'{29, 2, 1900, 0, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		'{30, 2, 2000, 0, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		'{31, 4, 2021, 0, 1'b1, 0, 0, 0, 0, ST_BAD_DATE},
		// carries, borrows across leap and common Februaries, full-range offsets
		'{28, 2, 2023, 1, 1'b0, 0, 0, 0, 0, ST_OK},
		'{31, 12, 2023, 1, 1'b0, 0, 0, 0, 0, ST_OK},
		'{1, 3, 2024, -1, 1'b0, 0, 0, 0, 0, ST_OK},
		'{1, 3, 2100, -1, 1'b0, 0, 0, 0, 0, ST_OK},
		'{1, 5, 2001, -31, 1'b0, 0, 0, 0, 0, ST_OK},
		'{15, 6, 2000, 32767, 1'b0, 0, 0, 0, 0, ST_OK},
		'{15, 6, 5000, -32768, 1'b0, 0, 0, 0, 0, ST_OK},
		'{1, 1, 1, 32767, 1'b0, 0, 0, 0, 0, ST_OK},
		'{31, 12, 9999, -32768, 1'b0, 0, 0, 0, 0, ST_OK}
	};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	gdo_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	gdo_rsp_t rsp;

	gdo_rsp_t pending_dates [$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	bit       calm = 1'b0;
	bit       hold_rsp = 1'b0;

	gregorian_date_offset_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Calendar predictor
	function automatic bit is_leap(input int y);
		return (y % 4 == 0) && ((y % CENTURY != 0) || (y % LEAP_CYCLE == 0));
	endfunction

	function automatic int days_in(input int m, input int y);
		int len;
		case (m)
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
			MONTH_FEB: len = is_leap(y) ? LEN_LEAP : LEN_FEB;
			default: len = LEN_LONG;
		endcase
		return len;
	endfunction

	function automatic gdo_rsp_t shifted_date(input gdo_req_t r);
		int       d;
		int       m;
		int       y;
		int       doy;
		int       k;
		gdo_rsp_t res;
		res = '0;
		d = r.in_day;
		m = r.in_month;
		y = r.in_year;
		if (y < YEAR_MIN || y > YEAR_MAX || m < MONTH_JAN || m > MONTH_DEC ||
			d < 1 || d > days_in(m, y)) begin
			res.status = ST_BAD_DATE;
			return res;
		end
		d = d + $signed(r.offset);
		// carry whole months forward
		while (d > days_in(m, y)) begin
			d = d - days_in(m, y);
			m++;
			if (m > MONTH_DEC) begin
				m = MONTH_JAN;
				y++;
				if (y > YEAR_MAX) begin
					res.status = ST_RANGE;
					return res;
				end
			end
		end
		// borrow the length of the previous month
		while (d <= 0) begin
			m--;
			if (m < MONTH_JAN) begin
				m = MONTH_DEC;
				y--;
				if (y < YEAR_MIN) begin
					res.status = ST_RANGE;
					return res;
				end
			end
			d = d + days_in(m, y);
		end
		doy = d;
		for (k = MONTH_JAN; k < m; k++)
			doy = doy + days_in(k, y);
		res.out_day     = d[4:0];
		res.out_month   = m[3:0];
		res.out_year    = y[13:0];
		res.day_of_year = doy[8:0];
		res.status      = ST_OK;
		return res;
	endfunction

	function automatic gdo_req_t pack_req(input int d, input int m, input int y, input int off);
		gdo_req_t r;
		r.in_day   = d[4:0];
		r.in_month = m[3:0];
		r.in_year  = y[13:0];
		r.offset   = off[OFFSET_WIDTH-1:0];
		return r;
	endfunction

	// Mostly short gaps, a few long ones, none in calm stretches
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 50)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random request: mostly valid dates with small offsets, some boundary years,
	// century years, full-range offsets, and raw noise over all field bits
	function automatic gdo_req_t rand_request();
		int pick;
		int d;
		int m;
		int y;
		int off;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return pack_req($urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), $urandom_range(0, 65535));
		m = $urandom_range(MONTH_JAN, MONTH_DEC);
		if (pick < 20)
			y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
		else if (pick < 30)
			y = CENTURY * $urandom_range(1, 99);
		else
			y = $urandom_range(YEAR_MIN, YEAR_MAX);
		d = $urandom_range(1, days_in(m, y));
		if (pick < 20)
			off = int'($urandom_range(0, 6000)) - 3000;
		else if (pick < 36)
			off = $urandom_range(0, 65535);
		else
			off = int'($urandom_range(0, 1600)) - 800;
		return pack_req(d, m, y, off);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINT)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Offer one request after a gap and wait for it to be taken
	task automatic send_date(input gdo_req_t r, input gdo_rsp_t want, input int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		pending_dates.push_back(want);
	endtask

	// Response side: random stalls plus one long hold-off to back up the core
	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp && !held) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20) begin
				stall_left = gap_len();
			end
			rsp_ready <= (stall_left == 0) && arst_n;
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Check each taken response against the oldest expectation
	always @(posedge clk) begin
		gdo_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_dates.size() == 0) begin
				report_mismatch($sformatf("unexpected response %p", rsp));
			end else begin
				want = pending_dates.pop_front();
				if (rsp.out_day !== want.out_day)
					report_mismatch($sformatf("out_day %0d, want %0d", rsp.out_day,
						want.out_day));
				if (rsp.out_month !== want.out_month)
					report_mismatch($sformatf("out_month %0d, want %0d", rsp.out_month,
						want.out_month));
				if (rsp.out_year !== want.out_year)
					report_mismatch($sformatf("out_year %0d, want %0d", rsp.out_year,
						want.out_year));
				if (rsp.day_of_year !== want.day_of_year)
					report_mismatch($sformatf("day_of_year %0d, want %0d", rsp.day_of_year,
						want.day_of_year));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", rsp.status,
						want.status));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Stimulus: directed table, then random requests
	initial begin
		gdo_req_t   r;
		gdo_rsp_t   want;
		date_case_t row;
		int         n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		for (n = 0; n < NUM_CASES; n++) begin
			row = date_table[n];
			r = pack_req(row.d, row.m, row.y, row.off);
			if (row.typed) begin
				want.out_day     = row.ed[4:0];
				want.out_month   = row.em[3:0];
				want.out_year    = row.ey[13:0];
				want.day_of_year = row.edoy[8:0];
				want.status      = row.est;
			end else begin
				want = shifted_date(r);
			end
			send_date(r, want, gap_len());
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 200 && n < 260);
			if (n == 150)
				hold_rsp = 1'b1;
			r = rand_request();
			send_date(r, shifted_date(r), gap_len());
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_dates.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", pending_dates.size()));

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
